### rtl/quaternion_vector_rotate_core_macros.svh
// Assertion macros for the quaternion vector rotate core.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle implication, checked out of reset.
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/qvr_pkg.sv
// Shared constants and types of the quaternion vector rotate core.
`default_nettype none
package qvr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  typedef enum logic [1:0] {
    CFG_QUAT_REAL = 2'd0,
    CFG_QUAT_I    = 2'd1,
    CFG_QUAT_J    = 2'd2,
    CFG_QUAT_K    = 2'd3
  } cfg_idx_e;

endpackage
`default_nettype wire

### rtl/quaternion_vector_rotate_core.sv
// Throughput: one word per cycle while the output is ready; a full stage holds while the next one cannot advance.
// Stages: two Hamilton product stages, magnitude, one restoring divide stage
// per quotient bit (DATA_WIDTH+2), round and saturate into the output register.
// Reset: asynchronous active low; clears valid bits, loads quaternion (1,0,0,0).
`default_nettype none
`include "quaternion_vector_rotate_core_macros.svh"
module quaternion_vector_rotate_core #(
  parameter int DATA_WIDTH = qvr_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = qvr_pkg::FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // vec_real, vec_i, vec_j, vec_k from bit 0 up, zero padded
  input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  wire logic [0:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // res_real, res_i, res_j, res_k from bit 0 up, zero padded
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // zero_quat, saturated
  output logic [1:0]                 m_axis_tuser
);

  localparam int DW     = DATA_WIDTH;
  localparam int QW     = DW + 1;
  localparam int TW     = 2*DW + 3;
  localparam int PW     = 3*DW + 6;
  localparam int NW     = 2*DW + 2;
  localparam int QB     = DW + 2;
  localparam int RW     = PW + 1;
  localparam int NS     = QB + 4;
  localparam int TDW    = ((4*DW+7)/8)*8;
  localparam int STG_T  = 0;
  localparam int STG_P  = 1;
  localparam int STG_D0 = 2;
  localparam int STG_O  = NS - 1;

  // configuration
  logic signed [DW-1:0] quat_q [4];
  logic        [NW-1:0] n2_q, n2_d;
  logic signed [QW-1:0] qs [4];
  logic signed [QW-1:0] qc [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= DW'(64'd1 << FRAC_BITS);
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else if (cfg_we_i) begin
      unique case (qvr_pkg::cfg_idx_e'(cfg_idx_i))
        qvr_pkg::CFG_QUAT_REAL: quat_q[0] <= cfg_data_i;
        qvr_pkg::CFG_QUAT_I:    quat_q[1] <= cfg_data_i;
        qvr_pkg::CFG_QUAT_J:    quat_q[2] <= cfg_data_i;
        qvr_pkg::CFG_QUAT_K:    quat_q[3] <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    logic signed [NW-1:0] acc;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      qs[c] = QW'(quat_q[c]);
      qc[c] = (c == 0) ? qs[c] : -qs[c];
      acc   = acc + NW'(qs[c]) * NW'(qs[c]);
    end
    n2_d = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n2_q <= '0;
    else         n2_q <= n2_d;
  end

  // stage handshake
  logic [NS-1:0] vld_q, en, func_q;

  always_comb begin
    en[STG_O] = !vld_q[STG_O] || m_axis_tready;
    for (int s = NS - 2; s >= 0; s--) en[s] = !vld_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int s = 1; s < NS; s++) if (en[s]) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) func_q[0] <= s_axis_tuser[0];
    for (int s = 1; s < NS; s++) if (en[s]) func_q[s] <= func_q[s-1];
  end

  assign s_axis_tready = en[0];

  // first Hamilton product
  logic signed [QW-1:0] a0 [4];
  logic signed [QW-1:0] b0 [4];
  logic signed [TW-1:0] m0 [4][4];
  logic signed [TW-1:0] t_d [4];
  logic signed [TW-1:0] t_q [4];

  always_comb begin
    b0[0] = s_axis_tuser[0] ? QW'($signed(s_axis_tdata[DW-1:0])) : '0;
    b0[1] = QW'($signed(s_axis_tdata[2*DW-1:DW]));
    b0[2] = QW'($signed(s_axis_tdata[3*DW-1:2*DW]));
    b0[3] = QW'($signed(s_axis_tdata[4*DW-1:3*DW]));
    for (int c = 0; c < 4; c++) a0[c] = s_axis_tuser[0] ? qc[c] : qs[c];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m0[i][j] = TW'(a0[i]) * TW'(b0[j]);
    t_d[0] = m0[0][0] - m0[1][1] - m0[2][2] - m0[3][3];
    t_d[1] = m0[0][1] + m0[1][0] + m0[2][3] - m0[3][2];
    t_d[2] = m0[0][2] - m0[1][3] + m0[2][0] + m0[3][1];
    t_d[3] = m0[0][3] + m0[1][2] - m0[2][1] + m0[3][0];
  end

  always_ff @(posedge clk_i) begin
    if (en[STG_T]) t_q <= t_d;
  end

  // second Hamilton product
  logic signed [QW-1:0] b1 [4];
  logic signed [PW-1:0] m1 [4][4];
  logic signed [PW-1:0] p_d [4];
  logic signed [PW-1:0] p_q [4];

  always_comb begin
    for (int c = 0; c < 4; c++) b1[c] = func_q[STG_T] ? qs[c] : qc[c];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) m1[i][j] = PW'(t_q[i]) * PW'(b1[j]);
    p_d[0] = m1[0][0] - m1[1][1] - m1[2][2] - m1[3][3];
    p_d[1] = m1[0][1] + m1[1][0] + m1[2][3] - m1[3][2];
    p_d[2] = m1[0][2] - m1[1][3] + m1[2][0] + m1[3][1];
    p_d[3] = m1[0][3] + m1[1][2] - m1[2][1] + m1[3][0];
  end

  always_ff @(posedge clk_i) begin
    if (en[STG_P]) p_q <= p_d;
  end

  // divider: remainder starts at twice the magnitude, giving one extra bit for rounding
  logic [RW-1:0] rem_q [QB+1][4];
  logic [QB-1:0] quo_q [QB+1][4];
  logic [3:0]    neg_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en[STG_D0]) begin
      for (int c = 0; c < 4; c++) begin
        neg_q[0][c] <= p_q[c][PW-1];
        rem_q[0][c] <= {(p_q[c][PW-1] ? PW'(-p_q[c]) : PW'(p_q[c])), 1'b0};
        quo_q[0][c] <= '0;
      end
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [RW-1:0] dsh;
    logic [RW-1:0] rem_d [4];
    logic [QB-1:0] quo_d [4];

    always_comb begin
      dsh = RW'(n2_q) << (QB - k);
      for (int c = 0; c < 4; c++) begin
        if (rem_q[k-1][c] >= dsh) begin
          rem_d[c] = rem_q[k-1][c] - dsh;
          quo_d[c] = quo_q[k-1][c] | (QB'(1) << (QB - k));
        end else begin
          rem_d[c] = rem_q[k-1][c];
          quo_d[c] = quo_q[k-1][c];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[STG_D0+k]) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // round, saturate, output register
  logic signed [DW-1:0] res_d [4];
  logic signed [DW-1:0] res_q [4];
  logic                 sat_d, sat_q, zq_q;

  always_comb begin
    logic [QB:0]   rnd;
    logic [QB-1:0] mag, lim;
    logic          clip;
    sat_d = 1'b0;
    for (int c = 0; c < 4; c++) begin
      rnd  = (QB+1)'(quo_q[QB][c]) + (QB+1)'(1);
      mag  = rnd[QB:1];
      lim  = neg_q[QB][c] ? (QB'(1) << (DW-1)) : ((QB'(1) << (DW-1)) - QB'(1));
      clip = mag > lim;
      if (clip) mag = lim;
      res_d[c] = neg_q[QB][c] ? DW'(-mag) : DW'(mag);
      if (c == 0 && !func_q[STG_O-1]) begin
        res_d[c] = '0;
        clip     = 1'b0;
      end
      if (n2_q == '0) begin
        res_d[c] = '0;
        clip     = 1'b0;
      end
      sat_d = sat_d | clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[STG_O]) begin
      res_q <= res_d;
      sat_q <= sat_d;
      zq_q  <= (n2_q == '0);
    end
  end

  assign m_axis_tvalid = vld_q[STG_O];
  assign m_axis_tdata  = TDW'({res_q[3], res_q[2], res_q[1], res_q[0]});
  assign m_axis_tuser  = {sat_q, zq_q};

  `QVR_ASSERT(a_zero_quat_clear, (m_axis_tvalid && zq_q) |-> (m_axis_tdata == '0 && !sat_q), "zero quaternion word not cleared")
  `QVR_ASSERT(a_rotate_real_zero, (m_axis_tvalid && !func_q[STG_O]) |-> (res_q[0] == '0), "rotate word has nonzero real part")
  `QVR_ASSERT(a_ready_when_empty, !vld_q[STG_O] |-> s_axis_tready, "input stalled with empty output")
  `QVR_ASSERT_NXT(a_accept_enters, (s_axis_tvalid && s_axis_tready), vld_q[0], "accepted word lost at entry")

endmodule
`default_nettype wire

### bench/tb_quaternion_vector_rotate_core.sv
// Testbench: quaternion rotate core against an integer sandwich-product predictor.
`timescale 1ns / 100ps
module tb_quaternion_vector_rotate_core;

  typedef struct {
    bit                     func;
    logic signed [15:0]     re, vi, vj, vk;
  } vec_word_t;

  typedef struct {
    logic [15:0] re, ri, rj, rk;
    bit          zq, sat;
  } rot_word_t;

  typedef longint quat_t [4];

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  quaternion_vector_rotate_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata),   // vec_real, vec_i, vec_j, vec_k
    .s_axis_tuser(s_tuser),   // func
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata),   // res_real, res_i, res_j, res_k
    .m_axis_tuser(m_tuser)    // zero_quat, saturated
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  vec_word_t  vec_pending[$];
  rot_word_t  rot_expected[$];
  vec_word_t  cur_vec;
  logic signed [15:0] rot_q [4] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
  int  errors = 0;
  bit  calm = 0;
  int  sent = 0;
  int  seen = 0;
  int  hold_reqs = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  task automatic add_vec(vec_word_t w);
    vec_pending.insert(vec_pending.size(), w);
  endtask

  function automatic quat_t hamilton(quat_t a, quat_t b);
    quat_t r;
    r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    r[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    return r;
  endfunction

  // round half away from zero, then clip to 16 bits
  function automatic logic [15:0] scale_round(longint p, longint n, inout bit sat);
    longint m, qt;
    m = (p < 0) ? -p : p;
    qt = m / n;
    if (2 * (m % n) >= n) qt++;
    if (p < 0) begin
      if (qt > 32768) begin sat = 1; qt = 32768; end
      return 16'(-qt);
    end
    if (qt > 32767) begin sat = 1; qt = 32767; end
    return 16'(qt);
  endfunction

  function automatic rot_word_t rotate(vec_word_t w);
    rot_word_t r;
    quat_t q, qc, v, p;
    longint n2;
    bit sat;
    r = '{default: '0};
    sat = 0;
    for (int c = 0; c < 4; c++) q[c] = rot_q[c];
    n2 = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
    if (n2 == 0) begin
      r.zq = 1;
      return r;
    end
    qc = '{q[0], -q[1], -q[2], -q[3]};
    v = '{w.func ? longint'(w.re) : 0, w.vi, w.vj, w.vk};
    if (!w.func) p = hamilton(hamilton(q, v), qc);
    else p = hamilton(hamilton(qc, v), q);
    if (w.func) r.re = scale_round(p[0], n2, sat);
    r.ri = scale_round(p[1], n2, sat);
    r.rj = scale_round(p[2], n2, sat);
    r.rk = scale_round(p[3], n2, sat);
    r.sat = sat;
    return r;
  endfunction

  // sender
  always @(posedge clk)
    if (s_tvalid && s_tready) begin
      rot_expected.insert(rot_expected.size(), rotate(cur_vec));
      sent++;
    end

  always @(negedge clk) begin
    if (!s_tvalid || sent != seen) begin
      seen = sent;
      if (vec_pending.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
        cur_vec = vec_pending.pop_front();
        s_tdata <= {cur_vec.vk, cur_vec.vj, cur_vec.vi, cur_vec.re};
        s_tuser <= cur_vec.func;
        s_tvalid <= 1;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 400;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 26;
    end
  end

  always @(posedge clk)
    if (m_tvalid && m_tready) begin
      rot_word_t w;
      if (rot_expected.size() == 0) begin
        report("unexpected word", m_tdata[15:0], 16'h0000);
      end else begin
        w = rot_expected.pop_front();
        if (m_tdata[15:0] !== w.re) report("res_real", m_tdata[15:0], w.re);
        if (m_tdata[31:16] !== w.ri) report("res_i", m_tdata[31:16], w.ri);
        if (m_tdata[47:32] !== w.rj) report("res_j", m_tdata[47:32], w.rj);
        if (m_tdata[63:48] !== w.rk) report("res_k", m_tdata[63:48], w.rk);
        if (m_tuser[0] !== w.zq) report("zero_quat", 16'(m_tuser[0]), 16'(w.zq));
        if (m_tuser[1] !== w.sat) report("saturated", 16'(m_tuser[1]), 16'(w.sat));
      end
    end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(64)) - 16'd32;
      3: return 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_word_t rand_vec();
    vec_word_t w;
    w.func = 1'($urandom_range(1));
    w.re = pick_comp();
    w.vi = pick_comp();
    w.vj = pick_comp();
    w.vk = pick_comp();
    return w;
  endfunction

  task automatic drain();
    wait (vec_pending.size() == 0 && !s_tvalid && rot_expected.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_quat(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
    logic [15:0] vals [4];
    vals = '{a, b, c, d};
    for (int n = 0; n < 4; n++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_idx <= qvr_pkg::cfg_idx_e'(n);
      cfg_data <= vals[n];
      rot_q[n] = vals[n];
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    vec_word_t d;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed words at reset quaternion
    add_vec('{0, 16'h0000, 16'h7fff, 16'h8000, 16'h0001});
    add_vec('{0, 16'h7fff, 16'h8000, 16'h8000, 16'h8000});
    add_vec('{1, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
    add_vec('{1, 16'h0000, 16'sd16384, 16'h0000, 16'h0000});
    add_vec('{1, 16'hffff, 16'hffff, 16'h0000, 16'h0001});
    add_vec('{0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
    drain();
    set_quat(16'sd11585, 0, 0, 16'sd11585);
    add_vec('{1, 16'h0000, 16'sd16384, 16'h0000, 16'h0000});
    add_vec('{0, 16'h1234, 16'h7fff, 16'h8000, 16'h7fff});
    add_vec('{1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    drain();
    set_quat(0, 0, 0, 0);
    add_vec('{0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    add_vec('{1, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
    drain();
    set_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_vec('{1, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000});
    add_vec('{0, 16'h0000, 16'h8000, 16'h8000, 16'h8000});
    drain();
    set_quat(16'h0001, 0, 0, 0);
    add_vec('{0, 16'h0000, 16'h0003, 16'hfffd, 16'h7fff});
    add_vec('{1, 16'h0002, 16'h0000, 16'h0000, 16'h0000});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        1: set_quat(16'sd16384, 0, 0, 0);
        2: set_quat(0, 0, 0, 0);
        default: set_quat(pick_comp(), pick_comp(), pick_comp(), pick_comp());
      endcase
      calm = (ph == 4);
      for (int n = 0; n < 130; n++) add_vec(rand_vec());
      if (ph == 3) begin
        @(posedge clk);
        hold_reqs++;
      end
      drain();
    end
    calm = 0;

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate_core.sv
bench/tb_quaternion_vector_rotate_core.sv
